@@ rtl/core/pgr_pkg.sv @@
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants of the packed glyph rasterizer.
// ----------------------------------------------------------------------------
package pgr_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int NUM_LANES  = 8;
	localparam int LANE_IDX_W = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OPACITY_W  = 5;
	localparam int SIZE_W     = 7;
	localparam int COORD_W    = 7;
	localparam int ALPHA_W    = 4;

	localparam logic [OPACITY_W-1:0] OPACITY_FULL = 5'd16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SMOOTH_MODE   = 3'd0,
		REG_FG_COLOR      = 3'd1,
		REG_BG_COLOR      = 3'd2,
		REG_OPACITY       = 3'd3,
		REG_DOUBLE_ENABLE = 3'd4,
		REG_GLYPH_WIDTH   = 3'd5,
		REG_GLYPH_HEIGHT  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                  smooth_mode;
		logic [PIXEL_BITS-1:0] fg_color;
		logic [PIXEL_BITS-1:0] bg_color;
		logic [OPACITY_W-1:0]  opacity;
		logic                  double_enable;
		logic [SIZE_W-1:0]     glyph_width;
		logic [SIZE_W-1:0]     glyph_height;
	} pgr_cfg_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] value;
		logic                  is_bg;
	} pgr_lane_t;

endpackage

@@ rtl/core/packed_glyph_rasterizer.sv @@
// ----------------------------------------------------------------------------
// packed_glyph_rasterizer
// Unpacks packed glyph bytes into coordinate-tagged pixels, mono or 4-bit
// alpha, with optional 2x2 pixel doubling.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   packed_byte
//   out       output     out_valid / out_ready pixel_x, pixel_y, pixel_value,
//                                              is_background, glyph_last
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// Eight lanes decode a byte in the cycle it is taken; the output stage then
// sends one pixel per cycle while not stalled: 8 pixels per mono byte, 2 per
// smooth byte, four times that with doubling, fewer on the byte that ends a glyph.
// The next byte is taken in the cycle the current one sends its final pixel.
// Reset clears the position counters and restores register defaults.
// A stalled output holds its pixel; stalls stop the walk and, in turn, input.
// ----------------------------------------------------------------------------
module packed_glyph_rasterizer
	import pgr_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            packed_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    pixel_x,
	output logic [COORD_W-1:0]    pixel_y,
	output logic [PIXEL_BITS-1:0] pixel_value,
	output logic                  is_background,
	output logic                  glyph_last
);

	pgr_cfg_t  cfg_q;
	pgr_lane_t lane_res [NUM_LANES];
	logic      bank_free;
	logic      load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smooth_mode   <= 1'b0;
			cfg_q.fg_color      <= 16'hFFFF;
			cfg_q.bg_color      <= '0;
			cfg_q.opacity       <= OPACITY_FULL;
			cfg_q.double_enable <= 1'b0;
			cfg_q.glyph_width   <= 7'd16;
			cfg_q.glyph_height  <= 7'd16;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SMOOTH_MODE:   cfg_q.smooth_mode   <= cfg_data[0];
				REG_FG_COLOR:      cfg_q.fg_color      <= cfg_data[PIXEL_BITS-1:0];
				REG_BG_COLOR:      cfg_q.bg_color      <= cfg_data[PIXEL_BITS-1:0];
				REG_OPACITY:       cfg_q.opacity       <= cfg_data[OPACITY_W-1:0];
				REG_DOUBLE_ENABLE: cfg_q.double_enable <= cfg_data[0];
				REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_data[SIZE_W-1:0];
				REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	generate
		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			pgr_lane #(
				.LANE(l)
			) u_lane (
				.packed_byte(packed_byte),
				.cfg        (cfg_q),
				.result     (lane_res[l])
			);
		end
	endgenerate

	assign in_ready = bank_free;
	assign load     = in_valid && bank_free;

	pgr_serializer #(
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
	) u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.lane_res     (lane_res),
		.load         (load),
		.bank_free    (bank_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_value  (pixel_value),
		.is_background(is_background),
		.glyph_last   (glyph_last)
	);

endmodule

@@ rtl/core/pgr_lane.sv @@
// ----------------------------------------------------------------------------
// pgr_lane
// One pixel lane: picks its bit or nibble of the byte and forms the pixel.
// ----------------------------------------------------------------------------
module pgr_lane
	import pgr_pkg::*;
#(
	parameter int LANE = 0
) (
	input  logic [7:0] packed_byte,
	input  pgr_cfg_t   cfg,
	output pgr_lane_t  result
);

	logic                 mono_bit;
	logic [ALPHA_W-1:0]   alpha;
	logic [ALPHA_W-1:0]   alpha_scaled;
	logic [8:0]           product;

	assign mono_bit = packed_byte[LANE_IDX_W'(NUM_LANES - 1 - LANE)];

	// lane 0 takes the high nibble in smooth mode, every other lane the low one
	assign alpha   = (LANE == 0) ? packed_byte[7:4] : packed_byte[3:0];
	assign product = 9'(alpha) * 9'(cfg.opacity);

	always_comb begin
		// opacity 16 and above leaves alpha untouched
		if (cfg.opacity < OPACITY_FULL) begin
			alpha_scaled = product[7:4];
		end else begin
			alpha_scaled = alpha;
		end
		if (cfg.smooth_mode) begin
			result.value = PIXEL_BITS'(alpha_scaled);
			result.is_bg = 1'b0;
		end else if (mono_bit) begin
			result.value = cfg.fg_color;
			result.is_bg = 1'b0;
		end else begin
			result.value = cfg.bg_color;
			result.is_bg = 1'b1;
		end
	end

endmodule

@@ rtl/core/pgr_serializer.sv @@
// ----------------------------------------------------------------------------
// pgr_serializer
// Holds one byte of lane results, walks the pixels in order, tracks the glyph
// position and drives the registered output stage.
// ----------------------------------------------------------------------------
module pgr_serializer
	import pgr_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgr_cfg_t              cfg,
	input  pgr_lane_t             lane_res [NUM_LANES],
	input  logic                  load,
	output logic                  bank_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    pixel_x,
	output logic [COORD_W-1:0]    pixel_y,
	output logic [PIXEL_BITS-1:0] pixel_value,
	output logic                  is_background,
	output logic                  glyph_last
);

	localparam int CW  = $clog2(MAX_GLYPH_WIDTH);
	localparam int RW  = $clog2(MAX_GLYPH_HEIGHT);
	localparam int MW  = ((CW > RW) ? CW : RW) + 1;
	localparam int SW  = (MW > 8) ? MW : 8;

	pgr_lane_t             bank_s1 [NUM_LANES];
	logic                  bank_v_q;
	logic [LANE_IDX_W-1:0] idx_q;
	logic [1:0]            sub_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;

	logic [SW-1:0]         w_eff, h_eff, col_p1, row_p1, xe, ye, xd, yd;
	logic                  col_wrap, row_wrap, glyph_end;
	logic                  emit, last_sub, pix_done, item_done;
	logic [LANE_IDX_W-1:0] last_idx;
	pgr_lane_t             cur;

	always_comb begin
		if (cfg.glyph_width == '0) begin
			w_eff = SW'(1);
		end else if (SW'(cfg.glyph_width) > SW'(MAX_GLYPH_WIDTH)) begin
			w_eff = SW'(MAX_GLYPH_WIDTH);
		end else begin
			w_eff = SW'(cfg.glyph_width);
		end
		if (cfg.glyph_height == '0) begin
			h_eff = SW'(1);
		end else if (SW'(cfg.glyph_height) > SW'(MAX_GLYPH_HEIGHT)) begin
			h_eff = SW'(MAX_GLYPH_HEIGHT);
		end else begin
			h_eff = SW'(cfg.glyph_height);
		end
	end

	assign col_p1    = SW'(col_q) + SW'(1);
	assign row_p1    = SW'(row_q) + SW'(1);
	assign col_wrap  = col_p1 >= w_eff;
	assign row_wrap  = row_p1 >= h_eff;
	assign glyph_end = col_wrap && row_wrap;

	assign last_idx  = cfg.smooth_mode ? LANE_IDX_W'(1) : LANE_IDX_W'(NUM_LANES - 1);
	assign cur       = bank_s1[idx_q];

	assign emit      = bank_v_q && (!out_valid || out_ready);
	assign last_sub  = !cfg.double_enable || (sub_q == 2'd3);
	assign pix_done  = emit && last_sub;
	// drop the rest of the byte once the glyph is complete
	assign item_done = pix_done && (glyph_end || idx_q == last_idx);
	assign bank_free = !bank_v_q || item_done;

	assign xe = SW'(col_q);
	assign ye = SW'(row_q);
	assign xd = {xe[SW-2:0], sub_q[0]};
	assign yd = {ye[SW-2:0], sub_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_v_q <= 1'b0;
			idx_q    <= '0;
			sub_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (load) begin
				bank_v_q <= 1'b1;
				idx_q    <= '0;
				sub_q    <= '0;
			end else if (item_done) begin
				bank_v_q <= 1'b0;
			end else if (pix_done) begin
				idx_q <= idx_q + LANE_IDX_W'(1);
				sub_q <= '0;
			end else if (emit) begin
				sub_q <= sub_q + 2'd1;
			end
			if (pix_done) begin
				if (col_wrap) begin
					col_q <= '0;
					if (row_wrap) begin
						row_q <= '0;
					end else begin
						row_q <= row_p1[RW-1:0];
					end
				end else begin
					col_q <= col_p1[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_s1 <= lane_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x       <= cfg.double_enable ? xd[COORD_W-1:0] : xe[COORD_W-1:0];
			pixel_y       <= cfg.double_enable ? yd[COORD_W-1:0] : ye[COORD_W-1:0];
			pixel_value   <= cur.value;
			is_background <= cur.is_bg;
			glyph_last    <= glyph_end && last_sub;
		end
	end

	// counters restart after the final pixel of a glyph
	a_glyph_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_done && glyph_end) |=> (col_q == '0 && row_q == '0))
		else $error("position counters did not restart after glyph end");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bank_v_q |-> (idx_q <= last_idx))
		else $error("pixel index ran past the byte");

	a_no_sub_single: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_v_q && !cfg.double_enable) |-> (sub_q == 2'd0))
		else $error("copy counter moved without doubling");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid)
		else $error("emitted pixel missing from output stage");

endmodule

@@ sim/pgr_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// pgr_pixel_checker
// Watches the configuration, byte and pixel channels of the packed glyph
// rasterizer. It keeps its own copy of the registers and the position
// counters, expands each accepted byte into the pixels it should produce,
// and compares every accepted pixel transaction against the oldest one.
// ----------------------------------------------------------------------------
module pgr_pixel_checker
	import pgr_pkg::*;
#(
	parameter int MAX_W = 64,
	parameter int MAX_H = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            packed_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [COORD_W-1:0]    pixel_x,
	input  logic [COORD_W-1:0]    pixel_y,
	input  logic [PIXEL_BITS-1:0] pixel_value,
	input  logic                  is_background,
	input  logic                  glyph_last,
	output int                    fail_count,
	output int                    pending,
	output int                    pixel_count
);

	typedef struct packed {
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic [PIXEL_BITS-1:0] value;
		logic                  bg;
		logic                  last;
	} pixel_t;

	pixel_t     pixel_queue[$];
	pgr_cfg_t   regs;
	logic [5:0] col;
	logic [5:0] row;

	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	task automatic push_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [PIXEL_BITS-1:0] value, input logic bg, input logic last);
		pixel_t p;
		p.x     = x;
		p.y     = y;
		p.value = value;
		p.bg    = bg;
		p.last  = last;
		pixel_queue.push_back(p);
	endtask

	// expand one byte into its pixels and advance the position counters
	task automatic rasterize_byte(input logic [7:0] b);
		int                    w;
		int                    h;
		int                    npix;
		int                    a;
		logic [PIXEL_BITS-1:0] value;
		logic                  bg;
		logic                  last;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		w    = clamp_size(regs.glyph_width, MAX_W);
		h    = clamp_size(regs.glyph_height, MAX_H);
		npix = regs.smooth_mode ? 2 : NUM_LANES;
		for (int i = 0; i < npix; i++) begin
			x    = COORD_W'(col);
			y    = COORD_W'(row);
			bg   = 1'b0;
			last = 1'b0;
			if (regs.smooth_mode) begin
				a = (i == 0) ? int'(b[7:4]) : int'(b[3:0]);
				if (regs.opacity < OPACITY_FULL)
					a = (a * int'(regs.opacity)) >> 4;
				value = PIXEL_BITS'(a);
			end else if (b[7-i]) begin
				value = regs.fg_color;
			end else begin
				value = regs.bg_color;
				bg    = 1'b1;
			end
			// a counter at or past a lowered size ends the row here
			if (int'(col) + 1 >= w) begin
				col = '0;
				if (int'(row) + 1 >= h) begin
					row  = '0;
					last = 1'b1;
				end else begin
					row = row + 1'b1;
				end
			end else begin
				col = col + 1'b1;
			end
			if (regs.double_enable) begin
				x = x << 1;
				y = y << 1;
				push_pixel(x, y, value, bg, 1'b0);
				push_pixel(x + 1'b1, y, value, bg, 1'b0);
				push_pixel(x, y + 1'b1, value, bg, 1'b0);
				push_pixel(x + 1'b1, y + 1'b1, value, bg, last);
			end else begin
				push_pixel(x, y, value, bg, last);
			end
			if (last)
				break;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t want;
		if (!arst_n) begin
			regs = '{smooth_mode: 1'b0, fg_color: 16'hFFFF, bg_color: '0,
				opacity: OPACITY_FULL, double_enable: 1'b0,
				glyph_width: 7'd16, glyph_height: 7'd16};
			col = '0;
			row = '0;
			pixel_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SMOOTH_MODE:   regs.smooth_mode   = cfg_data[0];
					REG_FG_COLOR:      regs.fg_color      = cfg_data;
					REG_BG_COLOR:      regs.bg_color      = cfg_data;
					REG_OPACITY:       regs.opacity       = cfg_data[OPACITY_W-1:0];
					REG_DOUBLE_ENABLE: regs.double_enable = cfg_data[0];
					REG_GLYPH_WIDTH:   regs.glyph_width   = cfg_data[SIZE_W-1:0];
					REG_GLYPH_HEIGHT:  regs.glyph_height  = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				rasterize_byte(packed_byte);
			if (out_valid && out_ready) begin
				pixel_count++;
				if (pixel_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected pixel x=%0d y=%0d value=%h bg=%b last=%b",
						$time, pixel_x, pixel_y, pixel_value, is_background, glyph_last);
				end else begin
					want = pixel_queue.pop_front();
					if (want.x !== pixel_x || want.y !== pixel_y || want.value !== pixel_value
							|| want.bg !== is_background || want.last !== glyph_last) begin
						fail_count++;
						$display("%0t: pixel mismatch, expected x=%0d y=%0d value=%h bg=%b last=%b",
							$time, want.x, want.y, want.value, want.bg, want.last);
						$display("%0t:                 actual   x=%0d y=%0d value=%h bg=%b last=%b",
							$time, pixel_x, pixel_y, pixel_value, is_background, glyph_last);
					end
				end
			end
		end
		pending = pixel_queue.size();
	end

endmodule

@@ sim/packed_glyph_rasterizer_test.sv @@
// ----------------------------------------------------------------------------
// packed_glyph_rasterizer_test
// Drives packed glyph bytes and register settings into the rasterizer, with
// random idling on both channels and one long output hold-off, and leaves
// the pixel checking to pgr_pixel_checker. Directed bytes cover mono and
// smooth mode, opacity extremes, doubling, size clamping and sizes lowered
// mid-glyph; random phases follow with random settings and bytes.
// ----------------------------------------------------------------------------
module packed_glyph_rasterizer_test;
	import pgr_pkg::*;

	localparam int                   MAX_W       = 64;
	localparam int                   MAX_H       = 64;
	localparam int                   STALL_LIMIT = 3000;
	localparam int                   HOLD_CYCLES = 300;
	localparam int                   RAND_PHASES = 8;
	localparam int                   PHASE_ITEMS = 10;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED  = 3'd7;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic [7:0]            packed_byte = '0;
	logic                  out_ready   = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [COORD_W-1:0]    pixel_x;
	logic [COORD_W-1:0]    pixel_y;
	logic [PIXEL_BITS-1:0] pixel_value;
	logic                  is_background;
	logic                  glyph_last;

	int fail_count;
	int pending;
	int pixel_count;
	int bytes_sent = 0;
	int settings   = 0;
	int quiet      = 0;
	bit tx_idle    = 1'b1;
	bit rx_idle    = 1'b1;
	bit hold_armed = 1'b0;
	bit hold_done  = 1'b0;

	always #5 clk = ~clk;

	packed_glyph_rasterizer #(
		.MAX_GLYPH_WIDTH (MAX_W),
		.MAX_GLYPH_HEIGHT(MAX_H)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_byte  (packed_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_value  (pixel_value),
		.is_background(is_background),
		.glyph_last   (glyph_last)
	);

	pgr_pixel_checker #(
		.MAX_W(MAX_W),
		.MAX_H(MAX_H)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_byte  (packed_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_value  (pixel_value),
		.is_background(is_background),
		.glyph_last   (glyph_last),
		.fail_count   (fail_count),
		.pending      (pending),
		.pixel_count  (pixel_count)
	);

	// pixel receiver; one long hold-off once armed
	initial begin
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
				hold_done = 1'b1;
			end
			out_ready <= !(rx_idle && $urandom_range(99) < 17);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("packed_glyph_rasterizer test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (tx_idle && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		packed_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// stop offering bytes and wait for every pending pixel
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_glyph(input logic smooth, input logic [15:0] fg, input logic [15:0] bg,
			input logic [OPACITY_W-1:0] opac, input logic dbl,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		write_reg(REG_SMOOTH_MODE, CFG_DATA_W'(smooth));
		write_reg(REG_FG_COLOR, fg);
		write_reg(REG_BG_COLOR, bg);
		write_reg(REG_OPACITY, CFG_DATA_W'(opac));
		write_reg(REG_DOUBLE_ENABLE, CFG_DATA_W'(dbl));
		write_reg(REG_GLYPH_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_GLYPH_HEIGHT, CFG_DATA_W'(h));
		settings++;
	endtask

	// mostly small glyphs so they end often; sometimes zero or oversized
	function automatic logic [SIZE_W-1:0] rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return SIZE_W'($urandom_range(1, 8));
		if (r < 80)
			return SIZE_W'($urandom_range(9, 64));
		if (r < 90)
			return '0;
		return SIZE_W'($urandom_range(65, 127));
	endfunction

	initial begin
		logic [OPACITY_W-1:0] opac;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: mono, 16x16
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h80);
		send_byte(8'h01);
		drain();

		// doubled 3x2 glyph: each byte runs past the end of the glyph
		set_glyph(1'b0, 16'($urandom), 16'($urandom), OPACITY_FULL, 1'b1, 7'd3, 7'd2);
		send_byte(8'h5A);
		send_byte(8'hC3);
		drain();

		// smooth mode across opacity zero, partial, over-range and full
		set_glyph(1'b1, 16'h0000, 16'hFFFF, 5'd0, 1'b0, 7'd4, 7'd4);
		send_byte(8'hFF);
		send_byte(8'h0F);
		drain();
		write_reg(REG_OPACITY, 16'd7);
		send_byte(8'hF1);
		drain();
		write_reg(REG_OPACITY, 16'd17);
		send_byte(8'h8F);
		drain();
		write_reg(REG_OPACITY, 16'd31);
		write_reg(REG_UNUSED, 16'h5555);
		send_byte(8'hFF);
		drain();
		write_reg(REG_OPACITY, CFG_DATA_W'(OPACITY_FULL));
		send_byte(8'hFE);
		drain();

		// zero sizes act as a 1x1 glyph
		set_glyph(1'b0, 16'hFFFF, 16'h0000, OPACITY_FULL, 1'b0, 7'd0, 7'd0);
		send_byte(8'hFF);
		drain();
		write_reg(REG_DOUBLE_ENABLE, 16'd1);
		send_byte(8'h00);
		drain();

		// oversized sizes saturate
		set_glyph(1'b0, 16'h1234, 16'hEDCB, OPACITY_FULL, 1'b1, 7'd127, 7'd100);
		send_byte(8'h96);
		drain();

		// width lowered below the column count in mid-row
		set_glyph(1'b0, 16'hAAAA, 16'h5555, OPACITY_FULL, 1'b0, 7'd40, 7'd64);
		repeat (4) send_byte(8'($urandom));
		drain();
		write_reg(REG_GLYPH_WIDTH, 16'd8);
		send_byte(8'h3C);
		drain();

		// height lowered below the row count in mid-glyph
		set_glyph(1'b0, 16'hFFFF, 16'h0000, OPACITY_FULL, 1'b0, 7'd1, 7'd64);
		send_byte(8'h0F);
		send_byte(8'hF0);
		drain();
		write_reg(REG_GLYPH_HEIGHT, 16'd4);
		send_byte(8'h69);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			opac = ($urandom_range(3) == 0) ? OPACITY_FULL : OPACITY_W'($urandom_range(31));
			if (p == 4)
				set_glyph(1'b0, 16'($urandom), 16'($urandom), opac, 1'b1, rand_size(),
					rand_size());
			else
				set_glyph(1'($urandom), 16'($urandom), 16'($urandom), opac, 1'($urandom),
					rand_size(), rand_size());
			tx_idle = (p != 2);
			rx_idle = (p != 2);
			if (p == 4)
				hold_armed = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_byte(8'($urandom_range(255)));
			drain();
		end

		repeat (20) @(negedge clk);
		$display("Ran %0d packed bytes under %0d register settings, %0d pixel transactions checked.",
			bytes_sent, settings, pixel_count);
		if (fail_count == 0)
			$display("packed_glyph_rasterizer test passed");
		else
			$display("packed_glyph_rasterizer test failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/pgr_pkg.sv
rtl/core/pgr_lane.sv
rtl/core/pgr_serializer.sv
rtl/core/packed_glyph_rasterizer.sv
sim/pgr_pixel_checker.sv
sim/packed_glyph_rasterizer_test.sv
